>>> design/bbph_pkg.sv
package bbph_pkg;

  // Default sizing of the bar stores.
  localparam int unsigned BAR_COUNT_DEF  = 256;
  localparam int unsigned POWER_BITS_DEF = 32;

  // Fixed field widths of the item channels.
  localparam int unsigned BAR_W     = 8;
  localparam int unsigned PORT_PW_W = 32;

  // Coefficients are unsigned Q0.16 held in 17 bits so that one is representable.
  localparam int unsigned COEFF_W = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;

  localparam logic [COEFF_W-1:0] ATTACK_RST  = 17'd16384;
  localparam logic [COEFF_W-1:0] RELEASE_RST = 17'd4096;
  localparam logic [COEFF_W-1:0] DECAY_RST   = 17'd65000;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_DECAY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [BAR_W-1:0]     bar_index;
    logic [PORT_PW_W-1:0] target_power;
  } in_item_t;

  typedef struct packed {
    logic [BAR_W-1:0]     bar_number;
    logic [PORT_PW_W-1:0] smoothed_power;
    logic [PORT_PW_W-1:0] held_peak;
  } out_item_t;

  // Status that the update pipeline reports to the input side.
  typedef struct packed {
    logic s1_free;
    logic hazard;
  } pipe_status_t;

  // A coefficient above one acts as exactly one.
  function automatic logic [COEFF_W-1:0] clamp_coeff(input logic [COEFF_W-1:0] c);
    clamp_coeff = (c > COEFF_ONE) ? COEFF_ONE : c;
  endfunction

endpackage

>>> design/bbph_store.sv
module bbph_store #(
  parameter int unsigned BAR_COUNT = bbph_pkg::BAR_COUNT_DEF,
  parameter int unsigned DATA_W    = 2 * bbph_pkg::POWER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(BAR_COUNT)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]            rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(BAR_COUNT)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]            wr_data_i,
  output logic                         busy_o
);

  localparam int unsigned AW = $clog2(BAR_COUNT);

  logic [DATA_W-1:0] mem [BAR_COUNT];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     clr_q;
  logic              busy_q;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  // The clearing sweep owns the write port until every entry holds zero.
  assign we    = busy_q || wr_en_i;
  assign waddr = busy_q ? clr_q : wr_addr_i;
  assign wdata = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= (we && (waddr == rd_addr_i)) ? wdata : mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(BAR_COUNT - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

>>> design/bbph_pipe.sv
module bbph_pipe #(
  parameter int unsigned BAR_COUNT  = bbph_pkg::BAR_COUNT_DEF,
  parameter int unsigned POWER_BITS = bbph_pkg::POWER_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  logic [$clog2(BAR_COUNT)-1:0]       addr_i,
  input  logic                               inr_i,
  input  logic [bbph_pkg::BAR_W-1:0]         bar_i,
  input  logic [POWER_BITS-1:0]              x_i,
  input  logic [POWER_BITS-1:0]              y_i,
  input  logic [POWER_BITS-1:0]              p_i,
  input  logic [bbph_pkg::COEFF_W-1:0]       attack_i,
  input  logic [bbph_pkg::COEFF_W-1:0]       release_i,
  input  logic [bbph_pkg::COEFF_W-1:0]       decay_i,
  output bbph_pkg::pipe_status_t             status_o,
  output logic                               wr_en_o,
  output logic [$clog2(BAR_COUNT)-1:0]       wr_addr_o,
  output logic [2*POWER_BITS-1:0]            wr_data_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bbph_pkg::out_item_t                out_item_o
);

  localparam int unsigned AW  = $clog2(BAR_COUNT);
  localparam int unsigned PB  = POWER_BITS;
  localparam int unsigned CW  = bbph_pkg::COEFF_W;
  localparam int unsigned FW  = bbph_pkg::FRAC_W;
  localparam int unsigned HW  = (PB > FW) ? (PB - FW) : 1;
  localparam int unsigned PW  = HW + CW;
  localparam int unsigned LW  = FW + CW;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned OW  = bbph_pkg::PORT_PW_W;
  localparam int unsigned XW  = (PB > OW) ? PB : OW;

  // Stage 1: item with the stored values just read.
  logic              s1_v_q, s1_inr_q;
  logic [bbph_pkg::BAR_W-1:0] s1_bar_q;
  logic [AW-1:0]     s1_addr_q;
  logic [PB-1:0]     s1_x_q;
  // Stage 2: gap and selected coefficient.
  logic              s2_v_q, s2_inr_q, s2_rise_q;
  logic [bbph_pkg::BAR_W-1:0] s2_bar_q;
  logic [AW-1:0]     s2_addr_q;
  logic [PB-1:0]     s2_y_q, s2_p_q, s2_diff_q;
  logic [CW-1:0]     s2_coef_q;
  // Stage 3: partial products.
  logic              s3_v_q, s3_inr_q, s3_rise_q;
  logic [bbph_pkg::BAR_W-1:0] s3_bar_q;
  logic [AW-1:0]     s3_addr_q;
  logic [PB-1:0]     s3_y_q;
  logic [PW-1:0]     s3_dhi_q, s3_phi_q;
  logic [LW-1:0]     s3_dlo_q, s3_plo_q;
  // Stage 4: scaled step and decayed peak.
  logic              s4_v_q, s4_inr_q, s4_rise_q;
  logic [bbph_pkg::BAR_W-1:0] s4_bar_q;
  logic [AW-1:0]     s4_addr_q;
  logic [PB-1:0]     s4_y_q, s4_step_q, s4_pdec_q;
  // Output register.
  logic              out_v_q;
  bbph_pkg::out_item_t out_q;

  logic          r1, r2, r3, r4, mv1, mv2, mv3, mv4, out_free;
  logic          rise;
  logic [PB-1:0] diff;
  logic [CW-1:0] coef;
  logic [PB-1:0] d_sh, p_sh;
  logic [HW-1:0] d_hi, p_hi;
  logic [SW-1:0] d_sum, p_sum;
  logic [PB-1:0] ny, np;
  logic [XW-1:0] ny_w, np_w;
  logic          m1, m2, m3, m4;

  assign out_free = !out_v_q || !out_stall_i;
  assign r4  = !s4_v_q || out_free;
  assign mv4 = s4_v_q && out_free;
  assign r3  = !s3_v_q || r4;
  assign mv3 = s3_v_q && r4;
  assign r2  = !s2_v_q || r3;
  assign mv2 = s2_v_q && r3;
  assign r1  = !s1_v_q || r2;
  assign mv1 = s1_v_q && r2;

  // A newer item for a bar must not read the store before the older write lands.
  // The write made in the same cycle as the read is bypassed inside the store.
  assign m1 = s1_v_q && s1_inr_q && (s1_addr_q == addr_i);
  assign m2 = s2_v_q && s2_inr_q && (s2_addr_q == addr_i);
  assign m3 = s3_v_q && s3_inr_q && (s3_addr_q == addr_i);
  assign m4 = s4_v_q && s4_inr_q && (s4_addr_q == addr_i) && !mv4;

  assign status_o.s1_free = r1;
  assign status_o.hazard  = inr_i && (m1 || m2 || m3 || m4);

  always_comb begin
    rise = s1_x_q > y_i;
    diff = rise ? (s1_x_q - y_i) : (y_i - s1_x_q);
    coef = rise ? attack_i : release_i;
  end

  assign d_sh = s2_diff_q >> FW;
  assign p_sh = s2_p_q >> FW;
  assign d_hi = d_sh[HW-1:0];
  assign p_hi = p_sh[HW-1:0];

  assign d_sum = SW'(s3_dhi_q) + SW'(s3_dlo_q[LW-1:FW]);
  assign p_sum = SW'(s3_phi_q) + SW'(s3_plo_q[LW-1:FW]);

  // The decayed peak never exceeds the old peak, so taking the larger of it and
  // the new smoothed value also covers the refresh case.
  assign ny   = s4_rise_q ? (s4_y_q + s4_step_q) : (s4_y_q - s4_step_q);
  assign np   = (ny > s4_pdec_q) ? ny : s4_pdec_q;
  assign ny_w = XW'(ny);
  assign np_w = XW'(np);

  assign wr_en_o   = mv4 && s4_inr_q;
  assign wr_addr_o = s4_addr_q;
  assign wr_data_o = {ny, np};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r1) begin
        s1_v_q <= acc_i;
      end
      if (r2) begin
        s2_v_q <= mv1;
      end
      if (r3) begin
        s3_v_q <= mv2;
      end
      if (r4) begin
        s4_v_q <= mv3;
      end
      if (out_free) begin
        out_v_q <= mv4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_inr_q  <= inr_i;
      s1_bar_q  <= bar_i;
      s1_addr_q <= addr_i;
      s1_x_q    <= x_i;
    end
    if (mv1) begin
      s2_inr_q  <= s1_inr_q;
      s2_bar_q  <= s1_bar_q;
      s2_addr_q <= s1_addr_q;
      s2_y_q    <= y_i;
      s2_p_q    <= p_i;
      s2_rise_q <= rise;
      s2_diff_q <= diff;
      s2_coef_q <= coef;
    end
    if (mv2) begin
      s3_inr_q  <= s2_inr_q;
      s3_bar_q  <= s2_bar_q;
      s3_addr_q <= s2_addr_q;
      s3_y_q    <= s2_y_q;
      s3_rise_q <= s2_rise_q;
      s3_dhi_q  <= PW'(d_hi) * PW'(s2_coef_q);
      s3_dlo_q  <= LW'(s2_diff_q[FW-1:0]) * LW'(s2_coef_q);
      s3_phi_q  <= PW'(p_hi) * PW'(decay_i);
      s3_plo_q  <= LW'(s2_p_q[FW-1:0]) * LW'(decay_i);
    end
    if (mv3) begin
      s4_inr_q  <= s3_inr_q;
      s4_bar_q  <= s3_bar_q;
      s4_addr_q <= s3_addr_q;
      s4_y_q    <= s3_y_q;
      s4_rise_q <= s3_rise_q;
      s4_step_q <= d_sum[PB-1:0];
      s4_pdec_q <= p_sum[PB-1:0];
    end
    if (mv4) begin
      out_q.bar_number     <= s4_bar_q;
      out_q.smoothed_power <= s4_inr_q ? ny_w[OW-1:0] : '0;
      out_q.held_peak      <= s4_inr_q ? np_w[OW-1:0] : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

>>> design/bar_ballistics_peak_hold.sv
// Per-bar display ballistics with peak hold for a spectrum display.
// Each input item names a bar and carries a new target power (unsigned Q16.16).
// The bar's smoothed power steps toward the target by the attack or release
// fraction, and its held peak either follows a new maximum or decays by the
// peak decay factor, never falling below the smoothed power. Each item yields
// exactly one result with the bar number and both updated values (zeros if out of range).
// Items flow in on in_valid_i/in_stall_o and results leave on
// out_valid_o/out_stall_i; an item moves when valid is high and stall is low.
// Coefficients are written on the cfg channel, which is always ready, and
// should only change while no item is in flight.
// An accepted item passes through stages 1 to 4 and then the output register.
// One item is taken every cycle as long as the pipeline has room and no item
// for the same bar is still within stages 1 to 4; a repeated bar waits until
// the earlier read-modify-write of the bar memory has been written back.
// A stalled receiver holds the output register and lets the pipeline
// fill its empty stages before it pushes back on the input.
// After reset the coefficients return to their defaults and a clearing pass
// zeroes the bar memory one entry per cycle; no item is accepted until it ends.
module bar_ballistics_peak_hold #(
  parameter int unsigned BAR_COUNT  = bbph_pkg::BAR_COUNT_DEF,
  parameter int unsigned POWER_BITS = bbph_pkg::POWER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bbph_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbph_pkg::COEFF_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bbph_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bbph_pkg::out_item_t             out_item_o
);

  localparam int unsigned AW = $clog2(BAR_COUNT);
  localparam int unsigned BW = bbph_pkg::BAR_W;
  // One spare bit so that BAR_COUNT itself is representable in the range check.
  localparam int unsigned IW = ((AW > BW) ? AW : BW) + 1;
  localparam int unsigned OW = bbph_pkg::PORT_PW_W;
  localparam int unsigned XW = (POWER_BITS > OW) ? POWER_BITS : OW;

  logic [bbph_pkg::COEFF_W-1:0] attack_q, release_q, decay_q;
  logic [IW-1:0]                bar_wide;
  logic                         in_range;
  logic [AW-1:0]                addr;
  logic [XW-1:0]                x_wide;
  logic [POWER_BITS-1:0]        x;
  logic                         accept;
  logic                         busy;
  bbph_pkg::pipe_status_t       status;
  logic [2*POWER_BITS-1:0]      rd_data;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [2*POWER_BITS-1:0]      wr_data;

  // Coefficients are stored already limited to one.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= bbph_pkg::ATTACK_RST;
      release_q <= bbph_pkg::RELEASE_RST;
      decay_q   <= bbph_pkg::DECAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbph_pkg::CFG_ATTACK:  attack_q  <= bbph_pkg::clamp_coeff(cfg_data_i);
        bbph_pkg::CFG_RELEASE: release_q <= bbph_pkg::clamp_coeff(cfg_data_i);
        bbph_pkg::CFG_DECAY:   decay_q   <= bbph_pkg::clamp_coeff(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Bars outside the store pass through with zero values and touch no state.
  assign bar_wide = IW'(in_item_i.bar_index);
  assign in_range = bar_wide < IW'(BAR_COUNT);
  assign addr     = bar_wide[AW-1:0];
  assign x_wide   = XW'(in_item_i.target_power);
  assign x        = x_wide[POWER_BITS-1:0];

  assign in_stall_o = busy || !status.s1_free || status.hazard;
  assign accept     = in_valid_i && !in_stall_o;

  bbph_store #(
    .BAR_COUNT (BAR_COUNT),
    .DATA_W    (2 * POWER_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .busy_o    (busy)
  );

  bbph_pipe #(
    .BAR_COUNT  (BAR_COUNT),
    .POWER_BITS (POWER_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (accept),
    .addr_i      (addr),
    .inr_i       (in_range),
    .bar_i       (in_item_i.bar_index),
    .x_i         (x),
    .y_i         (rd_data[2*POWER_BITS-1:POWER_BITS]),
    .p_i         (rd_data[POWER_BITS-1:0]),
    .attack_i    (attack_q),
    .release_i   (release_q),
    .decay_i     (decay_q),
    .status_o    (status),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
